FILE: rtl/mvmp_pkg.sv
// ----------------------------------------------------------------------------
// mvmp_pkg
// shared types, constants and helper functions of the motion vector median
// predictor
// ----------------------------------------------------------------------------
package mvmp_pkg;

  localparam int MV_W                     = 16;
  localparam int ROW_W                    = 8;
  localparam int COL_W                    = 6;
  localparam int IDX_W                    = COL_W + 1;
  localparam int MBS_W                    = 7;
  localparam int ADDR_MAX_W               = 10;
  localparam int IDX_COUNT                = 1 << IDX_W;
  localparam int MAX_MBS_PER_LINE_DEFAULT = 64;
  localparam int FIFO_DEPTH               = 2;

  localparam logic [MBS_W-1:0] MBS_PER_LINE_RESET = MBS_W'(40);

  typedef struct packed {
    logic [ROW_W-1:0]       row_index;
    logic [COL_W-1:0]       col_index;
    logic signed [MV_W-1:0] diff_x;
    logic signed [MV_W-1:0] diff_y;
  } in_t;

  typedef struct packed {
    logic signed [MV_W-1:0] mv_x;
    logic signed [MV_W-1:0] mv_y;
  } out_t;

  // x in the low half, y in the high half
  typedef struct packed {
    logic signed [MV_W-1:0] y;
    logic signed [MV_W-1:0] x;
  } vec_t;

  typedef enum logic [2:0] {
    PRED_ZERO,
    PRED_LEFT,
    PRED_FIRST_COL,
    PRED_LAST_COL,
    PRED_INTERIOR
  } pred_case_t;

  typedef struct packed {
    pred_case_t             pred_case;
    logic signed [MV_W-1:0] diff_x;
    logic signed [MV_W-1:0] diff_y;
  } dec_info_t;

  // column to line buffer slot, built by counting so no divider is needed
  function automatic logic [IDX_COUNT-1:0][ADDR_MAX_W-1:0] mod_table(int unsigned modulus);
    logic [IDX_COUNT-1:0][ADDR_MAX_W-1:0] tab;
    int unsigned r;
    r = 0;
    for (int i = 0; i < IDX_COUNT; i++) begin
      tab[i] = ADDR_MAX_W'(r);
      r = (r + 1 == modulus) ? 0 : r + 1;
    end
    return tab;
  endfunction

  function automatic logic signed [MV_W-1:0] med3(
    input logic signed [MV_W-1:0] a,
    input logic signed [MV_W-1:0] b,
    input logic signed [MV_W-1:0] c
  );
    logic signed [MV_W-1:0] lo;
    logic signed [MV_W-1:0] hi;
    logic signed [MV_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

FILE: rtl/mvmp_ram.sv
// ----------------------------------------------------------------------------
// mvmp_ram
// generic ram, one write port and two registered read ports, read-first
// ----------------------------------------------------------------------------
module mvmp_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [W-1:0]             rdata_a,
  output logic [W-1:0]             rdata_b
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/mvmp_fifo.sv
// ----------------------------------------------------------------------------
// mvmp_fifo
// small first-in first-out queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module mvmp_fifo #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int DEPTH = mvmp_pkg::FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: rtl/mvmp_front.sv
// ----------------------------------------------------------------------------
// mvmp_front
// accepts macroblock requests, picks the prediction case and the line buffer
// slots of the above and above-right neighbours, and queues them
// ----------------------------------------------------------------------------
module mvmp_front #(
  parameter int MAX_MBS_PER_LINE = mvmp_pkg::MAX_MBS_PER_LINE_DEFAULT,
  parameter int AW               = $clog2(MAX_MBS_PER_LINE)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  mvmp_pkg::in_t                  item,
  input  logic [mvmp_pkg::MBS_W-1:0]     mbs_per_line,
  input  logic                           dq_pop,
  output logic                           dq_empty,
  output mvmp_pkg::dec_info_t            dq_info,
  output logic [AW-1:0]                  dq_bi,
  output logic [AW-1:0]                  dq_ci
);

  localparam int IW = $bits(mvmp_pkg::dec_info_t);
  localparam int QW = IW + 2 * AW;
  localparam logic [mvmp_pkg::IDX_COUNT-1:0][mvmp_pkg::ADDR_MAX_W-1:0] MOD_TAB =
    mvmp_pkg::mod_table(MAX_MBS_PER_LINE);

  logic [mvmp_pkg::IDX_W-1:0] col_ext;
  logic [mvmp_pkg::IDX_W-1:0] col_next;
  logic                       row_zero;
  logic                       col_zero;
  logic                       last_col;
  mvmp_pkg::dec_info_t        info;
  logic [AW-1:0]              bi;
  logic [AW-1:0]              ci;
  logic [QW-1:0]              q_wdata;
  logic [QW-1:0]              q_rdata;

  assign col_ext  = mvmp_pkg::IDX_W'(item.col_index);
  assign col_next = col_ext + mvmp_pkg::IDX_W'(1);
  assign row_zero = (item.row_index == '0);
  assign col_zero = (item.col_index == '0);
  // a zero register value never matches since col+1 is at least one
  assign last_col = (col_next == mbs_per_line);

  assign bi = MOD_TAB[col_ext][AW-1:0];
  assign ci = MOD_TAB[col_next][AW-1:0];

  always_comb begin
    info.diff_x = item.diff_x;
    info.diff_y = item.diff_y;
    if (row_zero && col_zero) begin
      info.pred_case = mvmp_pkg::PRED_ZERO;
    end else if (row_zero) begin
      info.pred_case = mvmp_pkg::PRED_LEFT;
    end else if (col_zero) begin
      info.pred_case = mvmp_pkg::PRED_FIRST_COL;
    end else if (last_col) begin
      info.pred_case = mvmp_pkg::PRED_LAST_COL;
    end else begin
      info.pred_case = mvmp_pkg::PRED_INTERIOR;
    end
  end

  assign q_wdata = {info, bi, ci};

  mvmp_fifo #(
    .W (QW)
  ) u_dec_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (dq_pop),
    .rdata (q_rdata),
    .empty (dq_empty)
  );

  assign dq_info = mvmp_pkg::dec_info_t'(q_rdata[QW-1 -: IW]);
  assign dq_bi   = q_rdata[2*AW-1 -: AW];
  assign dq_ci   = q_rdata[AW-1:0];

endmodule

FILE: rtl/mvmp_back.sv
// ----------------------------------------------------------------------------
// mvmp_back
// reads the neighbours from the line buffer, forms the median prediction,
// adds the difference and writes the new vector back
// ----------------------------------------------------------------------------
module mvmp_back #(
  parameter int MAX_MBS_PER_LINE = mvmp_pkg::MAX_MBS_PER_LINE_DEFAULT,
  parameter int AW               = $clog2(MAX_MBS_PER_LINE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                dq_empty,
  output logic                dq_pop,
  input  mvmp_pkg::dec_info_t dq_info,
  input  logic [AW-1:0]       dq_bi,
  input  logic [AW-1:0]       dq_ci,
  input  logic                out_full,
  output logic                out_push,
  output mvmp_pkg::out_t      out_vec
);

  localparam int VW = $bits(mvmp_pkg::vec_t);

  logic                s2_valid;
  logic                s2_fire;
  logic                s2_free;
  mvmp_pkg::dec_info_t s2_info;
  logic [AW-1:0]       s2_bi;
  logic [AW-1:0]       s2_ci;
  mvmp_pkg::vec_t      left_vector;
  mvmp_pkg::vec_t      diag_vector;
  logic [AW-1:0]       wr_addr;
  mvmp_pkg::vec_t      wr_vec;
  logic [VW-1:0]       rd_b;
  logic [VW-1:0]       rd_c;
  mvmp_pkg::vec_t      b_vec;
  mvmp_pkg::vec_t      c_vec;
  mvmp_pkg::vec_t      new_vec;

  function automatic logic signed [mvmp_pkg::MV_W-1:0] predict(
    input mvmp_pkg::pred_case_t           pc,
    input logic signed [mvmp_pkg::MV_W-1:0] a,
    input logic signed [mvmp_pkg::MV_W-1:0] b,
    input logic signed [mvmp_pkg::MV_W-1:0] c,
    input logic signed [mvmp_pkg::MV_W-1:0] d
  );
    logic signed [mvmp_pkg::MV_W-1:0] p;
    unique case (pc)
      mvmp_pkg::PRED_ZERO:      p = '0;
      mvmp_pkg::PRED_LEFT:      p = a;
      mvmp_pkg::PRED_FIRST_COL: p = mvmp_pkg::med3('0, b, c);
      mvmp_pkg::PRED_LAST_COL:  p = mvmp_pkg::med3(a, b, d);
      mvmp_pkg::PRED_INTERIOR:  p = mvmp_pkg::med3(a, b, c);
      default:                  p = '0;
    endcase
    return p;
  endfunction

  assign s2_fire  = s2_valid && !out_full;
  assign s2_free  = !s2_valid || s2_fire;
  assign dq_pop   = !dq_empty && s2_free;
  assign out_push = s2_fire;

  mvmp_ram #(
    .W     (VW),
    .DEPTH (MAX_MBS_PER_LINE)
  ) u_line_buf (
    .clk     (clk),
    .we      (s2_fire),
    .waddr   (s2_bi),
    .wdata   (new_vec),
    .re      (dq_pop),
    .raddr_a (dq_bi),
    .raddr_b (dq_ci),
    .rdata_a (rd_b),
    .rdata_b (rd_c)
  );

  // the ram read misses the write made on the same edge, so the last write
  // is forwarded; an older last write matches what the ram already holds
  assign b_vec = (wr_addr == s2_bi) ? wr_vec : mvmp_pkg::vec_t'(rd_b);
  assign c_vec = (wr_addr == s2_ci) ? wr_vec : mvmp_pkg::vec_t'(rd_c);

  always_comb begin
    new_vec.x = predict(s2_info.pred_case, left_vector.x, b_vec.x, c_vec.x, diag_vector.x)
                + s2_info.diff_x;
    new_vec.y = predict(s2_info.pred_case, left_vector.y, b_vec.y, c_vec.y, diag_vector.y)
                + s2_info.diff_y;
  end

  assign out_vec.mv_x = new_vec.x;
  assign out_vec.mv_y = new_vec.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (dq_pop) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dq_pop) begin
      s2_info <= dq_info;
      s2_bi   <= dq_bi;
      s2_ci   <= dq_ci;
    end
    if (s2_fire) begin
      left_vector <= new_vec;
      diag_vector <= b_vec;
      wr_addr     <= s2_bi;
      wr_vec      <= new_vec;
    end
  end

endmodule

FILE: rtl/motion_vector_median_predictor.sv
// ----------------------------------------------------------------------------
// motion_vector_median_predictor
// rebuilds inter macroblock motion vectors from their differences using the
// median of the left, above and above-right neighbours
// ----------------------------------------------------------------------------
// One macroblock request is taken per cycle and one vector is returned per
// cycle when the result side pops every cycle; an accepted request passes
// through the decode queue and then the line buffer registered read, with
// prediction and add on the read data feeding the output queue, before its
// result is on the result ports. The line buffer holds one
// vector per column and has no clearing pass: a neighbour that was never
// written reads as anything, so requests must come in raster order from the
// first macroblock of a frame.
// Write mbs_per_line only while no request is in flight.
// ----------------------------------------------------------------------------
module motion_vector_median_predictor #(
  parameter int MAX_MBS_PER_LINE = mvmp_pkg::MAX_MBS_PER_LINE_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [mvmp_pkg::MBS_W-1:0] cfg_wr_data,
  input  logic                       push,
  output logic                       full,
  input  mvmp_pkg::in_t              item,
  output logic                       empty,
  input  logic                       pop,
  output mvmp_pkg::out_t             result
);

  localparam int AW = $clog2(MAX_MBS_PER_LINE);
  localparam int OW = $bits(mvmp_pkg::out_t);

  logic [mvmp_pkg::MBS_W-1:0] mbs_per_line;
  logic                       dq_pop;
  logic                       dq_empty;
  mvmp_pkg::dec_info_t        dq_info;
  logic [AW-1:0]              dq_bi;
  logic [AW-1:0]              dq_ci;
  logic                       out_full;
  logic                       out_push;
  mvmp_pkg::out_t             out_vec;
  logic [OW-1:0]              out_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      mbs_per_line <= mvmp_pkg::MBS_PER_LINE_RESET;
    end else if (cfg_wr_en) begin
      mbs_per_line <= cfg_wr_data;
    end
  end

  mvmp_front #(
    .MAX_MBS_PER_LINE (MAX_MBS_PER_LINE),
    .AW               (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .item         (item),
    .mbs_per_line (mbs_per_line),
    .dq_pop       (dq_pop),
    .dq_empty     (dq_empty),
    .dq_info      (dq_info),
    .dq_bi        (dq_bi),
    .dq_ci        (dq_ci)
  );

  mvmp_back #(
    .MAX_MBS_PER_LINE (MAX_MBS_PER_LINE),
    .AW               (AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dq_empty (dq_empty),
    .dq_pop   (dq_pop),
    .dq_info  (dq_info),
    .dq_bi    (dq_bi),
    .dq_ci    (dq_ci),
    .out_full (out_full),
    .out_push (out_push),
    .out_vec  (out_vec)
  );

  mvmp_fifo #(
    .W (OW)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_vec),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign result = mvmp_pkg::out_t'(out_rdata);

  a_no_push_when_out_full: assert property (
    @(posedge clk) disable iff (rst) out_push |-> !out_full
  ) else $error("result pushed into a full output queue");

  a_accept_fills_dec_queue: assert property (
    @(posedge clk) disable iff (rst) (push && !full) |=> !dq_empty
  ) else $error("accepted request missing from decode queue");

  a_result_visible: assert property (
    @(posedge clk) disable iff (rst) out_push |=> !empty
  ) else $error("finished result not visible on the result side");

endmodule

FILE: tb/mv_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mv_median_checker
// watches the request and result queues of the motion vector median
// predictor, rebuilds every vector from its own line buffer copy and compares
// each popped result with the oldest rebuilt one
// ----------------------------------------------------------------------------
module mv_median_checker #(
  parameter int LINE_SLOTS = mvmp_pkg::MAX_MBS_PER_LINE_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [mvmp_pkg::MBS_W-1:0] cfg_wr_data,
  input  logic                       push,
  input  logic                       full,
  input  mvmp_pkg::in_t              item,
  input  logic                       empty,
  input  logic                       pop,
  input  mvmp_pkg::out_t             result,
  output int                         errors,
  output int                         outstanding
);
  import mvmp_pkg::*;

  vec_t             line_buf [LINE_SLOTS];
  vec_t             left_vec;
  vec_t             diag_vec;
  logic [MBS_W-1:0] line_width;
  out_t             expected_mvs [$];

  function automatic logic signed [MV_W-1:0] median_of(
    input logic signed [MV_W-1:0] a,
    input logic signed [MV_W-1:0] b,
    input logic signed [MV_W-1:0] c
  );
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  task automatic rebuild_vector(input in_t req);
    vec_t       above;
    vec_t       above_right;
    vec_t       pred;
    vec_t       mv;
    out_t       exp_mv;
    pred_case_t kind;
    int         slot;
    int         next_slot;
    slot        = int'(req.col_index) % LINE_SLOTS;
    next_slot   = (int'(req.col_index) + 1) % LINE_SLOTS;
    above       = line_buf[slot];
    above_right = line_buf[next_slot];
    if (req.row_index == 0 && req.col_index == 0) kind = PRED_ZERO;
    else if (req.row_index == 0) kind = PRED_LEFT;
    else if (req.col_index == 0) kind = PRED_FIRST_COL;
    else if (int'(req.col_index) + 1 == int'(line_width)) kind = PRED_LAST_COL;
    else kind = PRED_INTERIOR;
    case (kind)
      PRED_ZERO: begin
        pred = '0;
      end
      PRED_LEFT: begin
        pred = left_vec;
      end
      PRED_FIRST_COL: begin
        // missing left neighbour counts as zero
        pred.x = median_of(16'sd0, above.x, above_right.x);
        pred.y = median_of(16'sd0, above.y, above_right.y);
      end
      PRED_LAST_COL: begin
        // above-left stands in for the missing above-right
        pred.x = median_of(left_vec.x, above.x, diag_vec.x);
        pred.y = median_of(left_vec.y, above.y, diag_vec.y);
      end
      default: begin
        pred.x = median_of(left_vec.x, above.x, above_right.x);
        pred.y = median_of(left_vec.y, above.y, above_right.y);
      end
    endcase
    mv.x           = pred.x + req.diff_x;
    mv.y           = pred.y + req.diff_y;
    diag_vec       = above;
    line_buf[slot] = mv;
    left_vec       = mv;
    exp_mv.mv_x    = mv.x;
    exp_mv.mv_y    = mv.y;
    expected_mvs.push_back(exp_mv);
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      expected_mvs.delete();
      line_width = MBS_PER_LINE_RESET;
      left_vec   = '0;
      diag_vec   = '0;
      for (int i = 0; i < LINE_SLOTS; i++) line_buf[i] = '0;
      errors = 0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) line_width = cfg_wr_data;
      if (push && !full) rebuild_vector(item);
      if (pop && !empty) begin
        if (expected_mvs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got mv_x %0d mv_y %0d",
                   $time, result.mv_x, result.mv_y);
          errors++;
        end else begin
          want = expected_mvs.pop_front();
          if (result.mv_x !== want.mv_x) begin
            $display("%0t: mv_x mismatch, expected %0d, got %0d",
                     $time, want.mv_x, result.mv_x);
            errors++;
          end
          if (result.mv_y !== want.mv_y) begin
            $display("%0t: mv_y mismatch, expected %0d, got %0d",
                     $time, want.mv_y, result.mv_y);
            errors++;
          end
        end
      end
      outstanding <= expected_mvs.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives macroblock requests into the motion vector median predictor
// ----------------------------------------------------------------------------
// A short directed frame on a narrow line covers every prediction case and
// the extreme differences, then random phases mix raster frames with stray
// requests over several line widths and idle patterns on both queues.
// Requests never make the block read a neighbour that nothing has written.
// ----------------------------------------------------------------------------
module tb;
  import mvmp_pkg::*;

  localparam int LINE_SLOTS      = MAX_MBS_PER_LINE_DEFAULT;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int CYCLE_LIMIT     = 400000;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [MBS_W-1:0] cfg_wr_data = '0;
  logic             push        = 1'b0;
  logic             full;
  in_t              item        = '0;
  logic             empty;
  logic             pop         = 1'b0;
  out_t             result;

  int errors;
  int outstanding;
  int cycles         = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  // stimulus-side view of which neighbours hold a written vector
  logic [MBS_W-1:0] line_width = MBS_PER_LINE_RESET;
  bit               line_seen [LINE_SLOTS];
  bit               left_seen  = 1'b0;
  bit               diag_seen  = 1'b0;

  logic [MBS_W-1:0] phase_widths [PHASES] =
    '{7'd64, 7'd2, 7'd40, 7'd3, 7'd64, 7'd17, 7'd63, 7'd2};
  logic [MV_W-1:0]  edge_diffs [5] =
    '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001};

  motion_vector_median_predictor #(
    .MAX_MBS_PER_LINE(LINE_SLOTS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  mv_median_checker #(
    .LINE_SLOTS(LINE_SLOTS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [MV_W-1:0] random_mv_diff();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return MV_W'($urandom);
      default: return MV_W'($urandom_range(16)) - 16'd8;
    endcase
  endfunction

  function automatic bit request_is_legal(input in_t req);
    int slot;
    slot = int'(req.col_index) % LINE_SLOTS;
    if (req.row_index == 0 && req.col_index == 0) return 1'b1;
    if (req.row_index == 0) return left_seen;
    if (req.col_index == 0) return line_seen[0] && line_seen[1];
    if (int'(req.col_index) + 1 == int'(line_width))
      return left_seen && line_seen[slot] && diag_seen;
    return left_seen && line_seen[slot] && line_seen[(slot + 1) % LINE_SLOTS];
  endfunction

  task automatic send_request(input in_t req);
    int slot;
    slot = int'(req.col_index) % LINE_SLOTS;
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    diag_seen       = line_seen[slot];
    line_seen[slot] = 1'b1;
    left_seen       = 1'b1;
  endtask

  // hold requests back until every result has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_line_width(input logic [MBS_W-1:0] w);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    line_width = w;
  endtask

  initial begin : stimulus
    in_t req;
    int  sent;
    int  nrows;
    int  tries;
    int  n;
    bit  legal;
    bit  paused;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // narrow frame: every prediction case with extreme differences
    write_line_width(7'd4);
    n = 0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        req.row_index = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'h7F : 8'hFF;
        req.col_index = COL_W'(c);
        req.diff_x    = edge_diffs[n % 5];
        req.diff_y    = edge_diffs[(3 * n + 1) % 5];
        send_request(req);
        n++;
      end
    end
    // requests out of raster order
    req = '{row_index: 8'h55, col_index: 6'd1, diff_x: 16'h8000, diff_y: 16'h7FFF};
    send_request(req);
    req = '{row_index: 8'hAA, col_index: 6'd3, diff_x: 16'hFFFF, diff_y: 16'h0001};
    send_request(req);
    req = '{row_index: 8'h00, col_index: 6'd2, diff_x: 16'h0000, diff_y: 16'h8000};
    send_request(req);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_line_width(phase_widths[phase]);
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 80; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 80; end
        default: begin send_gap_pct = 11; recv_stall_pct = 11; end
      endcase
      sent   = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if ((phase % 2) == 1 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(9) < 7) begin
          // raster frame starting at the first macroblock
          nrows = $urandom_range(1, 3);
          for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < int'(line_width); c++) begin
              req.row_index = (r == 0) ? 8'd0 : ROW_W'($urandom_range(1, 255));
              req.col_index = COL_W'(c);
              req.diff_x    = random_mv_diff();
              req.diff_y    = random_mv_diff();
              send_request(req);
              sent++;
            end
          end
        end else begin
          // stray requests anywhere on the line, beyond its end included
          repeat ($urandom_range(1, 8)) begin
            tries = 0;
            legal = 1'b0;
            while (!legal && tries < 16) begin
              req.row_index = $urandom_range(1) ? 8'd0 : ROW_W'($urandom);
              req.col_index = ($urandom_range(3) == 0) ? COL_W'(line_width - 7'd1)
                                                       : COL_W'($urandom);
              req.diff_x    = random_mv_diff();
              req.diff_y    = random_mv_diff();
              legal = request_is_legal(req);
              tries++;
            end
            if (!legal) begin
              req.row_index = '0;
              req.col_index = '0;
            end
            send_request(req);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: motion_vector_median_predictor.f
rtl/mvmp_pkg.sv
rtl/mvmp_ram.sv
rtl/mvmp_fifo.sv
rtl/mvmp_front.sv
rtl/mvmp_back.sv
rtl/motion_vector_median_predictor.sv
tb/mv_median_checker.sv
tb/tb.sv
